// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Default number of cells in the chain
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int PRIO_W     = 8;
    localparam int ENTRY_CNT_W = 5;

    // Beat widths, whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Operation codes carried in s_tuser
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // One stored entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    // Command broadcast to every cell in the chain
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ent;
    } cell_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      slot_valid,
    input  logic      left_keep,
    input  entry_t    left_ent,
    input  entry_t    right_ent,
    output logic      keep,
    output entry_t    ent
);

    entry_t ent_reg;
    entry_t ent_next;

    // Stay in place when this entry is served no later than the new one
    assign keep = slot_valid && (ent_reg.prio <= cmd.ent.prio);
    assign ent  = ent_reg;

    // Hold, take the new entry, shift right on insert, shift left on removal
    always_comb begin
        ent_next = ent_reg;
        if (cmd.enq) begin
            if (keep) begin
                ent_next = ent_reg;
            end else if (left_keep) begin
                ent_next = cmd.ent;
            end else begin
                ent_next = left_ent;
            end
        end else if (cmd.deq) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

// ----- rtl/stable_priority_queue.sv -----
// Top level of the stable priority queue: cell chain, entry count and result register.
//
//  channel | dir | handshake         | tdata fields (low bit up)
//  --------+-----+-------------------+-------------------------------------------------
//  s_      | in  | s_tvalid/s_tready | item_data[31:0], item_priority[39:32]; tuser mode
//  m_      | out | m_tvalid/m_tready | out_data, out_valid, overflow, underflow,
//          |     |                   | entry_count, is_empty, zero fill to 48 bits
//
// One operation is taken per cycle while m_ is not stalled; every cell of the chain
// compares and shifts in the same edge that writes the result into the output register.
// The single output register decouples the sides: a new beat is taken while the
// previous result is being taken downstream, and s_tready drops only while m_ is stalled.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
`timescale 1ns / 1ps

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // item_data[31:0], item_priority[39:32]
    input  logic                 s_tuser,  // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // out_data[31:0], out_valid[32], overflow[33],
                                           // underflow[34], entry_count[39:35],
                                           // is_empty[40], zero[47:41]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic      accept;
    logic      full;
    logic      empty;
    logic      op_deq;
    cell_cmd_t cmd;

    entry_t cell_ent [CAPACITY];
    logic   keep_chain [CAPACITY+1];

    logic [DATA_W-1:0]      res_data;
    logic                   res_valid;
    logic                   res_oflow;
    logic                   res_uflow;
    logic [ENTRY_CNT_W-1:0] res_count;
    logic                   res_empty;

    // Take a beat whenever the output register is free or being emptied
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op_deq   = (s_tuser == MODE_DEQ);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Broadcast the operation to the chain
    always_comb begin
        cmd.enq      = accept && !op_deq && !full;
        cmd.deq      = accept && op_deq && !empty;
        cmd.ent.data = s_tdata[DATA_W-1:0];
        cmd.ent.prio = s_tdata[DATA_W+PRIO_W-1:DATA_W];
    end

    // Row of cells, slot 0 at the head
    assign keep_chain[0] = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_ent;
        entry_t right_ent;

        if (i == 0) begin : g_head
            assign left_ent = cmd.ent;
        end else begin : g_body
            assign left_ent = cell_ent[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_ent = cmd.ent;
        end else begin : g_inner
            assign right_ent = cell_ent[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .slot_valid (CNT_W'(i) < count_reg),
            .left_keep  (keep_chain[i]),
            .left_ent   (left_ent),
            .right_ent  (right_ent),
            .keep       (keep_chain[i+1]),
            .ent        (cell_ent[i])
        );
    end

    // Advance the entry count
    always_comb begin
        count_next = count_reg;
        if (cmd.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.deq) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Report the low bits of the new count
    if (CNT_W >= ENTRY_CNT_W) begin : g_cnt_trim
        assign res_count = count_next[ENTRY_CNT_W-1:0];
    end else begin : g_cnt_pad
        assign res_count = ENTRY_CNT_W'(count_next);
    end

    // Build the result beat
    always_comb begin
        res_valid = cmd.deq;
        res_data  = cmd.deq ? cell_ent[0].data : '0;
        res_oflow = accept && !op_deq && full;
        res_uflow = accept && op_deq && empty;
        res_empty = (count_next == '0);
        m_tdata_next = {7'd0, res_empty, res_count, res_uflow, res_oflow, res_valid, res_data};
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Count never passes the number of cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Head two entries stay in priority order
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_ent[0].prio <= cell_ent[1].prio))
        else $error("chain head out of order");

    // A stored enqueue grows the count by one
    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not grow count");

    // A result never reports a word together with a fault
    a_res_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[32] && (m_tdata_reg[33] || m_tdata_reg[34])))
        else $error("result flags conflict");

endmodule
